// File: hdl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern string matcher.
// Depends on nothing; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mpsm_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_ALPHABET  = 26;

   localparam logic [7:0] FIRST_SYMBOL = 8'd97;

   localparam logic [2:0] ACT_PATTERN_CHAR = 3'd0;
   localparam logic [2:0] ACT_END_PATTERN  = 3'd1;
   localparam logic [2:0] ACT_BUILD_LINKS  = 3'd2;
   localparam logic [2:0] ACT_TEXT_CHAR    = 3'd3;
   localparam logic [2:0] ACT_RESTART_TEXT = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] matches_here;
      logic [31:0] total_matches;
   } rsp_type;

endpackage

// File: hdl/multi_pattern_string_matcher.sv
// Top level of the multi-pattern string matcher (Aho-Corasick automaton).
// Depends on mpsm_pkg for the beat structs, action and status codes.
`timescale 1ns / 1ps

// The matcher keeps its trie in two synchronous memories with registered reads: a
// child table of MAX_NODES*ALPHABET entries and a node table holding, per node, the
// failure link, pattern count, output count and one slot of the breadth-first queue.
// After reset a clearing pass writes zero through the child table, one entry per
// cycle, and the block stalls its request channel until the pass ends. One request
// beat is worked on at a time, and the next one is taken as soon as the result is
// handed to the output register, even while that register still waits on a stalled
// response channel. A pattern character or an end of pattern passes through dispatch,
// one work state and done; a restart, an unused action or a pattern or text character
// outside a to z goes from dispatch straight to done. A text character reads its
// child, then that node's output count, and each failure link followed costs one
// node-table read and one child-table read. A build walks every node in breadth-first
// order: it pops a node, then reads each of its ALPHABET child slots; for every child
// found it resolves the failure link, following failure links below the root, writes
// the link and the output count and queues the child, so its length grows with the
// node count times ALPHABET. Pattern or text characters outside a to z give status 2;
// a text character of that kind sends the scan back to the root. Patterns added after
// a build need a new build beat.
module multi_pattern_string_matcher #(
   parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES,
   parameter int ALPHABET  = mpsm_pkg::DEF_ALPHABET
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpsm_pkg::rsp_type rsp_data
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int NCW   = NW + 1;
   localparam int SW    = $clog2(ALPHABET);
   localparam int CDEP  = MAX_NODES * ALPHABET;
   localparam int CAW   = $clog2(CDEP);

   typedef struct packed {
      logic [NW-1:0] queue;
      logic [NW-1:0] fail;
      logic [15:0]   pcnt;
      logic [15:0]   ocnt;
   } node_entry_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_P_CHK, S_E_WR, S_F_CHK, S_F_FAIL, S_T_OCNT,
      S_B_ROOT, S_B_POP, S_B_POP1, S_B_POP2, S_B_CH, S_B_CH1, S_B_CRD1, S_B_CRD2,
      S_B_Q, S_DONE
   } state_type;

   function automatic logic [CAW-1:0] child_addr(input logic [NW-1:0] node,
                                                 input logic [SW-1:0] sym);
      child_addr = CAW'(node) * CAW'(ALPHABET) + CAW'(sym);
   endfunction

   function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat16 = s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Memories.
   logic [NW-1:0]  child_mem [CDEP];
   node_entry_type node_mem  [MAX_NODES];
   logic [NW-1:0]  child_rd_ff;
   node_entry_type node_rd_ff;

   // Control and working registers.
   state_type        state_ff;
   logic [CAW-1:0]   clr_ff;
   logic [2:0]       action_ff;
   logic [SW-1:0]    sym_ff;
   logic             sym_ok_ff;
   logic [NCW-1:0]   nodes_used_ff;
   logic [NW-1:0]    cur_ff;
   logic [NW-1:0]    scan_ff;
   logic [31:0]      total_ff;
   logic [1:0]       status_ff;
   logic [15:0]      here_ff;
   logic [NW-1:0]    node_ff;
   logic [SW-1:0]    fsym_ff;
   logic [NCW-1:0]   head_ff;
   logic [NCW-1:0]   tail_ff;
   logic [NW-1:0]    p_ff;
   logic [NW-1:0]    fp_ff;
   logic [SW-1:0]    i_ff;
   logic [NW-1:0]    c_ff;
   logic [NW-1:0]    f_ff;
   logic [15:0]      pc_ff;
   logic             rsp_valid_ff;
   mpsm_pkg::rsp_type rsp_data_ff;

   // Request decode.
   logic [8:0] sym_diff;
   logic       req_sym_ok;
   assign sym_diff   = {1'b0, req_data.symbol} - {1'b0, mpsm_pkg::FIRST_SYMBOL};
   assign req_sym_ok = !sym_diff[8] && (sym_diff < 9'(ALPHABET));

   // Memory port controls.
   logic [NW-1:0]  cr_node;
   logic [SW-1:0]  cr_sym;
   logic           cw_en;
   logic [CAW-1:0] cw_addr;
   logic [NW-1:0]  cw_data;
   logic [NW-1:0]  nr_addr;
   logic [NW-1:0]  nw_addr;
   logic           nw_queue_en;
   logic           nw_fail_en;
   logic           nw_pcnt_en;
   logic           nw_ocnt_en;
   node_entry_type nw_data;

   logic last_sym;
   logic follow_more;
   logic room;
   assign last_sym    = (i_ff == SW'(ALPHABET - 1));
   assign follow_more = (node_ff != '0) && (child_rd_ff == '0);
   assign room        = (nodes_used_ff < NCW'(MAX_NODES));

   always_comb begin
      cr_node     = '0;
      cr_sym      = '0;
      cw_en       = 1'b0;
      cw_addr     = child_addr(cur_ff, sym_ff);
      cw_data     = nodes_used_ff[NW-1:0];
      nr_addr     = '0;
      nw_addr     = '0;
      nw_queue_en = 1'b0;
      nw_fail_en  = 1'b0;
      nw_pcnt_en  = 1'b0;
      nw_ocnt_en  = 1'b0;
      nw_data     = '0;
      case (state_ff)
         S_CLEAR: begin
            cw_en   = 1'b1;
            cw_addr = clr_ff;
            cw_data = '0;
            nw_addr = clr_ff[NW-1:0];
            if (clr_ff < CAW'(MAX_NODES)) begin
               nw_fail_en = 1'b1;
               nw_pcnt_en = 1'b1;
               nw_ocnt_en = 1'b1;
            end
         end
         S_DISPATCH: begin
            case (action_ff)
               mpsm_pkg::ACT_PATTERN_CHAR: begin
                  cr_node = cur_ff;
                  cr_sym  = sym_ff;
               end
               mpsm_pkg::ACT_END_PATTERN: nr_addr = cur_ff;
               mpsm_pkg::ACT_TEXT_CHAR: begin
                  cr_node = scan_ff;
                  cr_sym  = sym_ff;
               end
               default: nr_addr = '0;
            endcase
         end
         S_P_CHK: begin
            cw_en = (child_rd_ff == '0) && room;
         end
         S_E_WR: begin
            nw_addr      = cur_ff;
            nw_pcnt_en   = 1'b1;
            nw_data.pcnt = sat16(node_rd_ff.pcnt, 16'd1);
         end
         S_F_CHK: begin
            if (follow_more) begin
               nr_addr = node_ff;
            end else if (action_ff == mpsm_pkg::ACT_BUILD_LINKS) begin
               nr_addr = c_ff;
            end else begin
               nr_addr = child_rd_ff;
            end
         end
         S_F_FAIL: begin
            cr_node = node_rd_ff.fail;
            cr_sym  = fsym_ff;
         end
         S_B_ROOT: begin
            nw_queue_en = 1'b1;
            nw_fail_en  = 1'b1;
            nw_ocnt_en  = 1'b1;
            nw_data.ocnt = node_rd_ff.pcnt;
         end
         S_B_POP:  nr_addr = head_ff[NW-1:0];
         S_B_POP1: nr_addr = node_rd_ff.queue;
         S_B_POP2: cr_node = p_ff;
         S_B_CH: begin
            cr_node = p_ff;
            cr_sym  = i_ff;
         end
         S_B_CH1: begin
            if (p_ff == '0) begin
               nr_addr = child_rd_ff;
            end else begin
               cr_node = fp_ff;
               cr_sym  = i_ff;
            end
         end
         S_B_CRD1: nr_addr = f_ff;
         S_B_CRD2: begin
            nw_addr      = c_ff;
            nw_fail_en   = 1'b1;
            nw_ocnt_en   = 1'b1;
            nw_data.fail = f_ff;
            nw_data.ocnt = sat16(pc_ff, node_rd_ff.ocnt);
         end
         S_B_Q: begin
            nw_addr       = tail_ff[NW-1:0];
            nw_queue_en   = (tail_ff < NCW'(MAX_NODES));
            nw_data.queue = c_ff;
         end
         default: nr_addr = '0;
      endcase
   end

   // Child table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cw_en) begin
         child_mem[cw_addr] <= cw_data;
      end
      child_rd_ff <= child_mem[child_addr(cr_node, cr_sym)];
   end

   // Node table: one write address with per-field enables, one registered read port.
   always_ff @(posedge clock) begin
      if (nw_queue_en) begin
         node_mem[nw_addr].queue <= nw_data.queue;
      end
      if (nw_fail_en) begin
         node_mem[nw_addr].fail <= nw_data.fail;
      end
      if (nw_pcnt_en) begin
         node_mem[nw_addr].pcnt <= nw_data.pcnt;
      end
      if (nw_ocnt_en) begin
         node_mem[nw_addr].ocnt <= nw_data.ocnt;
      end
      node_rd_ff <= node_mem[nr_addr];
   end

   logic [32:0] total_sum;
   assign total_sum = {1'b0, total_ff} + {17'd0, node_rd_ff.ocnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         nodes_used_ff <= NCW'(1);
         cur_ff        <= '0;
         scan_ff       <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The done state reloads the output register itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CAW'(1);
               if (clr_ff == CAW'(CDEP - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  action_ff <= req_data.action;
                  sym_ff    <= sym_diff[SW-1:0];
                  sym_ok_ff <= req_sym_ok;
                  status_ff <= mpsm_pkg::STATUS_OK;
                  here_ff   <= '0;
                  state_ff  <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               case (action_ff)
                  mpsm_pkg::ACT_PATTERN_CHAR: begin
                     if (!sym_ok_ff) begin
                        status_ff <= mpsm_pkg::STATUS_BAD_SYMBOL;
                        state_ff  <= S_DONE;
                     end else begin
                        state_ff <= S_P_CHK;
                     end
                  end
                  mpsm_pkg::ACT_END_PATTERN: state_ff <= S_E_WR;
                  mpsm_pkg::ACT_BUILD_LINKS: state_ff <= S_B_ROOT;
                  mpsm_pkg::ACT_TEXT_CHAR: begin
                     if (!sym_ok_ff) begin
                        status_ff <= mpsm_pkg::STATUS_BAD_SYMBOL;
                        scan_ff   <= '0;
                        state_ff  <= S_DONE;
                     end else begin
                        node_ff  <= scan_ff;
                        fsym_ff  <= sym_ff;
                        state_ff <= S_F_CHK;
                     end
                  end
                  mpsm_pkg::ACT_RESTART_TEXT: begin
                     scan_ff  <= '0;
                     total_ff <= '0;
                     state_ff <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_P_CHK: begin
               if (child_rd_ff != '0) begin
                  cur_ff <= child_rd_ff;
               end else if (!room) begin
                  status_ff <= mpsm_pkg::STATUS_TABLE_FULL;
               end else begin
                  cur_ff        <= nodes_used_ff[NW-1:0];
                  nodes_used_ff <= nodes_used_ff + NCW'(1);
               end
               state_ff <= S_DONE;
            end
            S_E_WR: begin
               cur_ff   <= '0;
               state_ff <= S_DONE;
            end
            S_F_CHK: begin
               if (follow_more) begin
                  state_ff <= S_F_FAIL;
               end else if (action_ff == mpsm_pkg::ACT_BUILD_LINKS) begin
                  f_ff     <= child_rd_ff;
                  state_ff <= S_B_CRD1;
               end else begin
                  scan_ff  <= child_rd_ff;
                  state_ff <= S_T_OCNT;
               end
            end
            S_F_FAIL: begin
               node_ff  <= node_rd_ff.fail;
               state_ff <= S_F_CHK;
            end
            S_T_OCNT: begin
               here_ff  <= node_rd_ff.ocnt;
               total_ff <= total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
               state_ff <= S_DONE;
            end
            S_B_ROOT: begin
               head_ff  <= '0;
               tail_ff  <= NCW'(1);
               state_ff <= S_B_POP;
            end
            S_B_POP: begin
               state_ff <= (head_ff < tail_ff) ? S_B_POP1 : S_DONE;
            end
            S_B_POP1: begin
               p_ff     <= node_rd_ff.queue;
               head_ff  <= head_ff + NCW'(1);
               state_ff <= S_B_POP2;
            end
            S_B_POP2: begin
               fp_ff    <= node_rd_ff.fail;
               i_ff     <= '0;
               state_ff <= S_B_CH1;
            end
            S_B_CH: state_ff <= S_B_CH1;
            S_B_CH1: begin
               if (child_rd_ff == '0) begin
                  if (last_sym) begin
                     state_ff <= S_B_POP;
                  end else begin
                     i_ff     <= i_ff + SW'(1);
                     state_ff <= S_B_CH;
                  end
               end else begin
                  c_ff <= child_rd_ff;
                  if (p_ff == '0) begin
                     f_ff     <= '0;
                     state_ff <= S_B_CRD1;
                  end else begin
                     node_ff  <= fp_ff;
                     fsym_ff  <= i_ff;
                     state_ff <= S_F_CHK;
                  end
               end
            end
            S_B_CRD1: begin
               pc_ff    <= node_rd_ff.pcnt;
               state_ff <= S_B_CRD2;
            end
            S_B_CRD2: state_ff <= S_B_Q;
            S_B_Q: begin
               if (tail_ff < NCW'(MAX_NODES)) begin
                  tail_ff <= tail_ff + NCW'(1);
               end
               if (last_sym) begin
                  state_ff <= S_B_POP;
               end else begin
                  i_ff     <= i_ff + SW'(1);
                  state_ff <= S_B_CH;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.status        <= status_ff;
                  rsp_data_ff.matches_here  <= here_ff;
                  rsp_data_ff.total_matches <= total_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/mpsm_checker.sv
// Checker for the multi-pattern string matcher: watches both channels, predicts every
// result beat from its own copy of the automaton and compares field by field.
// Depends on mpsm_pkg for the beat structs, action and status codes.
`timescale 1ns / 1ps

module mpsm_checker #(
   parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES,
   parameter int ALPHABET  = mpsm_pkg::DEF_ALPHABET
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mpsm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  mpsm_pkg::rsp_type rsp_data,
   output int                failures,
   output int                pending
);

   logic [9:0]  trie_child [MAX_NODES*ALPHABET];
   logic [9:0]  fail_node  [MAX_NODES];
   logic [15:0] own_count  [MAX_NODES];
   logic [15:0] out_count  [MAX_NODES];
   int unsigned node_total;
   logic [9:0]  cursor;
   logic [9:0]  scan_node;
   logic [31:0] match_sum;

   mpsm_pkg::rsp_type expected_rsp [$];

   function automatic logic [15:0] add_sat16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Walks the failure chain from a node until one has a child on the symbol.
   function automatic logic [9:0] goto_node(logic [9:0] from, int sym);
      logic [9:0] n;
      int guard;
      n = from;
      guard = 0;
      while (n != 0 && trie_child[n*ALPHABET+sym] == 0 && guard < MAX_NODES) begin
         n = fail_node[n];
         guard++;
      end
      return trie_child[n*ALPHABET+sym];
   endfunction

   function automatic void build_failure_links();
      logic [9:0] bfs [MAX_NODES];
      int head, tail, p, c;
      logic [9:0] f;
      head = 0;
      tail = 0;
      fail_node[0] = 0;
      out_count[0] = own_count[0];
      bfs[tail++] = 0;
      while (head < tail) begin
         p = bfs[head++];
         for (int i = 0; i < ALPHABET; i++) begin
            c = trie_child[p*ALPHABET+i];
            if (c != 0) begin
               f = (p == 0) ? 10'd0 : goto_node(fail_node[p], i);
               fail_node[c] = f;
               out_count[c] = add_sat16(own_count[c], out_count[f]);
               if (tail < MAX_NODES) bfs[tail++] = 10'(c);
            end
         end
      end
   endfunction

   function automatic mpsm_pkg::rsp_type predict_match(mpsm_pkg::req_type r);
      mpsm_pkg::rsp_type res;
      logic    letter;
      int      sym, slot;
      logic [32:0] s;
      letter = r.symbol >= mpsm_pkg::FIRST_SYMBOL &&
               (r.symbol - mpsm_pkg::FIRST_SYMBOL) < ALPHABET;
      sym = letter ? r.symbol - mpsm_pkg::FIRST_SYMBOL : 0;
      res.status = mpsm_pkg::STATUS_OK;
      res.matches_here = '0;
      case (r.action)
         mpsm_pkg::ACT_PATTERN_CHAR: begin
            if (!letter) begin
               res.status = mpsm_pkg::STATUS_BAD_SYMBOL;
            end else begin
               slot = cursor*ALPHABET + sym;
               if (trie_child[slot] == 0 && node_total >= MAX_NODES) begin
                  res.status = mpsm_pkg::STATUS_TABLE_FULL;
               end else begin
                  if (trie_child[slot] == 0) begin
                     trie_child[slot] = node_total[9:0];
                     node_total++;
                  end
                  cursor = trie_child[slot];
               end
            end
         end
         mpsm_pkg::ACT_END_PATTERN: begin
            own_count[cursor] = add_sat16(own_count[cursor], 16'd1);
            cursor = 0;
         end
         mpsm_pkg::ACT_BUILD_LINKS: build_failure_links();
         mpsm_pkg::ACT_TEXT_CHAR: begin
            if (!letter) begin
               res.status = mpsm_pkg::STATUS_BAD_SYMBOL;
               scan_node = 0;
            end else begin
               scan_node = goto_node(scan_node, sym);
               res.matches_here = out_count[scan_node];
               s = match_sum + res.matches_here;
               match_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
            end
         end
         mpsm_pkg::ACT_RESTART_TEXT: begin
            scan_node = 0;
            match_sum = 0;
         end
         default: ;
      endcase
      res.total_matches = match_sum;
      return res;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      mpsm_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         foreach (trie_child[i]) trie_child[i] = '0;
         foreach (fail_node[i]) begin
            fail_node[i] = '0;
            own_count[i] = '0;
            out_count[i] = '0;
         end
         node_total = 1;
         cursor = 0;
         scan_node = 0;
         match_sum = 0;
         expected_rsp.delete();
         failures <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               errs++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.matches_here !== want.matches_here) begin
                  $error("matches_here: expected %0d, got %0d",
                         want.matches_here, rsp_data.matches_here);
                  errs++;
               end
               if (rsp_data.total_matches !== want.total_matches) begin
                  $error("total_matches: expected %0d, got %0d",
                         want.total_matches, rsp_data.total_matches);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) expected_rsp.push_back(predict_match(req_data));
         if (errs != 0) failures <= failures + errs;
      end
   end

endmodule

// File: tb/tb_top.sv
// Top of the matcher testbench: makes clock, reset, request beats and response stalls,
// and gives the verdict. Depends on mpsm_pkg, the matcher RTL and mpsm_checker.
`timescale 1ns / 1ps

module tb_top;

   // Generous bound: the clearing pass, a full-table build, the smaller builds,
   // and every beat paying its worst gap and stall, taken several times over.
   localparam int CYCLE_LIMIT = 4_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   mpsm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   mpsm_pkg::rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycle_count = 0;

   // Sender pacing: a burst of beats back to back, then a gap with valid low.
   int burst_left = 0;
   bit pacing_off = 1'b0;

   // The stimulus bumps hold_asks to ask the receiver for one long hold-off.
   int hold_asks = 0;
   int hold_done = 0;
   int hold_left = 0;
   int stall_style = 0;

   multi_pattern_string_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   mpsm_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The timeout watchdog counts every cycle from the start, clearing pass included.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: the stall style is redrawn at random and one style never stalls, so that
   // some stretches run without any stall at all. A requested hold-off keeps stall high
   // long enough for the output register to fill and the request side to back up.
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) stall_style <= $urandom_range(0, 3);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_asks) begin
         hold_done <= hold_asks;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= (cycle_count % 5 < 2);
         endcase
      end
   end

   // Offers one beat and returns once req_stall is low. Valid is lowered only for a gap,
   // so a beat that follows straight on keeps valid high with one assignment.
   task automatic offer_beat(logic [2:0] action, logic [7:0] symbol);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = pacing_off ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{action: action, symbol: symbol};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic feed_pattern(string word);
      foreach (word[i]) offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, word[i]);
      offer_beat(mpsm_pkg::ACT_END_PATTERN, 8'd0);
   endtask

   task automatic feed_text(string line);
      foreach (line[i]) offer_beat(mpsm_pkg::ACT_TEXT_CHAR, line[i]);
   endtask

   function automatic logic [7:0] pick_letter(int span);
      return mpsm_pkg::FIRST_SYMBOL + 8'($urandom_range(0, span - 1));
   endfunction

   // Anything outside a to z, spread over the whole byte so each bit toggles.
   function automatic logic [7:0] pick_non_letter();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b >= mpsm_pkg::FIRST_SYMBOL && b < mpsm_pkg::FIRST_SYMBOL + 8'd26);
      return b;
   endfunction

   initial begin
      int span, n_words, len, text_len;
      logic [2:0] junk;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: empty trie, bad symbols at both edges of the letter range,
      // the classic he/she/hers set, unused actions, an empty pattern that
      // matches everywhere, and a pattern added after the build without a rebuild.
      offer_beat(mpsm_pkg::ACT_TEXT_CHAR, "a");
      offer_beat(mpsm_pkg::ACT_TEXT_CHAR, 8'h60);
      offer_beat(mpsm_pkg::ACT_TEXT_CHAR, 8'h7B);
      offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, 8'hFF);
      offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, 8'h00);
      feed_pattern("he");
      feed_pattern("she");
      feed_pattern("hers");
      offer_beat(mpsm_pkg::ACT_BUILD_LINKS, 8'd0);
      feed_text("ushers");
      offer_beat(3'd5, 8'hAA);
      offer_beat(3'd7, 8'h55);
      offer_beat(mpsm_pkg::ACT_RESTART_TEXT, 8'd0);
      offer_beat(mpsm_pkg::ACT_END_PATTERN, 8'd0);
      feed_pattern("z");
      feed_text("sz");
      drain_results();

      // Random phases: pattern sets over a narrow alphabet (all 26 letters in odd phases),
      // a build except in phase 4, then text from those letters, with some noise mixed in.
      for (int phase = 0; phase < 6; phase++) begin
         pacing_off = (phase == 3);
         span = (phase % 2) ? 26 : $urandom_range(2, 4);
         n_words = $urandom_range(1, 5);
         for (int w = 0; w < n_words; w++) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0)
                  offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, pick_non_letter());
               offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, pick_letter(span));
            end
            offer_beat(mpsm_pkg::ACT_END_PATTERN, 8'd0);
         end
         if (phase != 4) offer_beat(mpsm_pkg::ACT_BUILD_LINKS, 8'd0);
         if (phase == 1) hold_asks++;
         text_len = $urandom_range(15, 35);
         for (int k = 0; k < text_len; k++) begin
            case ($urandom_range(0, 29))
               0: offer_beat(mpsm_pkg::ACT_TEXT_CHAR, pick_non_letter());
               1: offer_beat(mpsm_pkg::ACT_RESTART_TEXT, 8'($urandom_range(0, 255)));
               2: begin
                  junk = 3'($urandom_range(5, 7));
                  offer_beat(junk, 8'($urandom_range(0, 255)));
               end
               default: offer_beat(mpsm_pkg::ACT_TEXT_CHAR, pick_letter(span));
            endcase
         end
         // In phase 2 the sender waits here until every expected result has come back.
         if (phase == 2) drain_results();
      end
      pacing_off = 1'b0;

      // Fill the node table with long random words, enough letters for insertions to be refused.
      for (int k = 0; k < 1080; ) begin
         len = $urandom_range(20, 40);
         for (int c = 0; c < len; c++, k++)
            offer_beat(mpsm_pkg::ACT_PATTERN_CHAR, pick_letter(26));
         offer_beat(mpsm_pkg::ACT_END_PATTERN, 8'd0);
      end
      offer_beat(mpsm_pkg::ACT_BUILD_LINKS, 8'd0);
      for (int k = 0; k < 80; k++) offer_beat(mpsm_pkg::ACT_TEXT_CHAR, pick_letter(26));

      drain_results();
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
hdl/mpsm_pkg.sv
hdl/multi_pattern_string_matcher.sv
tb/mpsm_checker.sv
tb/tb_top.sv
